### rtl/stbs_pkg.sv
// Shared types and codes for the sorted table binary search core.
package stbs_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic read;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
  } status_t;

endpackage

### rtl/sorted_table_binary_search_core.sv
// Top level of the sorted table binary search core.
// Usage:
//   Configuration: write table_length on cfg_data with cfg_valid; cfg_ready is
//   always high, so the write lands at that clock edge. Write it only when idle.
//   Input channel (in_valid / in_stall): operation 0 loads key_value into
//   entry entry_index; operation 1 searches for key_value starting at the
//   offset start_hint (taken as 0 if at or beyond the length in use).
//   A load produces no result. A search result is registered after P
//   probes (one registered memory read and one compare each, at most
//   log2(depth) + 2); an empty table takes no probe.
//   The core handles one request at a time; in_stall is high from the
//   acceptance of a search until its result is registered.
//   Output channel (out_valid / out_stall): found, probe_index and
//   insert_position sit in an output register. While the receiver stalls, the
//   result holds and loads are still taken; a following search finishes its
//   probes and waits until the output register is free.
//   Reset clears table_length and all control state; the key table contents
//   are undefined until loaded.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [9:0]  entry_index,
  input  logic [31:0] key_value,
  input  logic [9:0]  start_hint,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [9:0]  probe_index,
  output logic [10:0] insert_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import stbs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .entry_index     (entry_index),
    .key_value       (key_value),
    .start_hint      (start_hint),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .found           (found),
    .probe_index     (probe_index),
    .insert_position (insert_position)
  );

endmodule

### rtl/stbs_ctrl.sv
// Sequencing state machine for loads, probes and result hand-off.
module stbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  output logic             out_valid,
  input  logic             out_stall,
  output stbs_pkg::cmd_t    cmd,
  input  stbs_pkg::status_t status
);
  import stbs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = status.empty ? ST_DONE : ST_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.hit || status.last) begin
          state_next = ST_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        // hold the result until the output register can take it
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/stbs_dp.sv
// Key table memory, search window registers, length register and result register.
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  stbs_pkg::cmd_t     cmd,
  output stbs_pkg::status_t  status,
  input  logic [9:0]        entry_index,
  input  logic [31:0]       key_value,
  input  logic [9:0]        start_hint,
  input  logic              cfg_valid,
  input  logic [10:0]       cfg_data,
  output logic              found,
  output logic [9:0]        probe_index,
  output logic [10:0]       insert_position
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];

  logic [10:0]          table_length;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] rd_data;
  logic [LW-1:0]        len_q;
  logic [AW-1:0]        base_q;
  logic [AW-1:0]        off_q;
  logic                 empty_q;

  logic [LW-1:0]        len_eff;
  logic [AW-1:0]        addr;
  logic [LW-1:0]        len_rest;
  logic                 eq;
  logic                 gt;
  logic [AW:0]          pos;

  // a length above the table depth acts as the full depth
  assign len_eff  = (32'(table_length) > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : LW'(table_length);
  assign addr     = base_q + off_q;
  assign len_rest = len_q - LW'(off_q);
  assign eq       = (rd_data == key_q);
  assign gt       = (rd_data > key_q);
  assign pos      = {1'b0, addr} + (AW + 1)'(!eq && !gt);

  assign status.empty = (len_eff == '0);
  assign status.hit   = eq;
  assign status.last  = (len_q <= LW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (cfg_valid) begin
      table_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(entry_index) < TABLE_DEPTH)) begin
      key_table[AW'(entry_index)] <= KEY_WIDTH'(key_value);
    end
    if (cmd.read) begin
      rd_data <= key_table[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_q   <= KEY_WIDTH'(key_value);
      len_q   <= len_eff;
      base_q  <= '0;
      off_q   <= (32'(start_hint) >= 32'(len_eff)) ? '0 : AW'(start_hint);
      empty_q <= (len_eff == '0);
    end else if (cmd.step) begin
      if (gt) begin
        // element above the key: shrink the window to the offset
        len_q <= LW'(off_q);
        off_q <= off_q >> 1;
      end else begin
        // element below the key: move the base to the probe
        base_q <= addr;
        len_q  <= len_rest;
        off_q  <= AW'(len_rest >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      found           <= !empty_q && eq;
      probe_index     <= empty_q ? '0 : 10'(addr);
      insert_position <= empty_q ? '0 : (eq ? 11'(addr) : 11'(pos));
    end
  end

endmodule
